FILE: rtl/hrm_pkg.sv
// Shared types and constants for the heartbeat rate monitor.
// Used by every module of the block; depends on nothing.
package hrm_pkg;

  typedef enum logic {
    OpEvent = 1'b0,
    OpCheck = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StNormal   = 2'd0,
    StTooLow   = 2'd1,
    StTooHigh  = 2'd2,
    StNoEvents = 2'd3
  } status_e;

  typedef enum logic {
    RegLowLimit  = 1'b0,
    RegHighLimit = 1'b1
  } reg_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned ScaleW = 20;
  localparam logic [ScaleW-1:0] UsPerSec = 20'd1000000;
  localparam int unsigned FracW = 16;
  localparam int unsigned ProdW = DataW + ScaleW;
  localparam int unsigned DvdW = ProdW + FracW;
  localparam int unsigned StepW = $clog2(DvdW);

  localparam logic [DataW-1:0] LowLimitRst = 32'd11796;
  localparam logic [DataW-1:0] HighLimitRst = 32'd7208960;

  typedef struct packed {
    logic ev_take;
    logic chk_read;
    logic chk_update;
    logic mult;
    logic div_start;
    logic out_load;
  } hrm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } hrm_sts_t;

endpackage

FILE: rtl/hrm_div.sv
// Restoring bit-serial divider with a saturated 32-bit quotient.
// Depends on hrm_pkg for the dividend width and step count.
module hrm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hrm_pkg::DvdW-1:0]   dividend_i,
  input  logic [hrm_pkg::DataW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [hrm_pkg::DataW-1:0]  quot_o
);
  import hrm_pkg::*;

  logic [DvdW-1:0]  dvd_q;
  logic [DataW-1:0] dsr_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic             ovf_q;
  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] cnt_q;

  logic [DataW:0]   rem_sh;
  logic [DataW:0]   diff;
  logic             q_bit;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DvdW-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    q_bit  = ~diff[DataW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepW'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= q_bit ? diff[DataW-1:0] : rem_sh[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], q_bit};
      ovf_q <= ovf_q | quo_q[DataW-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = ovf_q ? '1 : quo_q;

endmodule

FILE: rtl/hrm_ctrl.sv
// Controller state machine that sequences event and check items.
// Depends on hrm_pkg for the command and status structs.
module hrm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              op_i,
  output logic              in_stall_o,
  input  hrm_pkg::hrm_sts_t sts_i,
  output hrm_pkg::hrm_cmd_t cmd_o
);
  import hrm_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SCalc,
    SMult,
    SDivStart,
    SDivWait,
    SFinish
  } state_e;

  state_e state_q;
  logic   take;

  assign take = (state_q == SIdle) && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      case (state_q)
        SIdle: begin
          if (take && (op_i == OpCheck)) begin
            state_q <= SCalc;
          end
        end
        SCalc:     state_q <= SMult;
        SMult:     state_q <= SDivStart;
        SDivStart: state_q <= SDivWait;
        SDivWait: begin
          if (sts_i.div_done) begin
            state_q <= SFinish;
          end
        end
        SFinish: begin
          if (sts_i.out_free) begin
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.ev_take    = take && (op_i == OpEvent);
    cmd_o.chk_read   = take && (op_i == OpCheck);
    cmd_o.chk_update = (state_q == SCalc);
    cmd_o.mult       = (state_q == SMult);
    cmd_o.div_start  = (state_q == SDivStart);
    cmd_o.out_load   = (state_q == SFinish) && sts_i.out_free;
  end

  assign in_stall_o = (state_q != SIdle);

endmodule

FILE: rtl/hrm_datapath.sv
// Datapath: event counter, held heartbeat fields, sample ring, rate
// arithmetic, classification and output register. Uses hrm_pkg and hrm_div.
module hrm_datapath #(
  parameter int unsigned WINDOW_DEPTH = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hrm_pkg::hrm_cmd_t         cmd_i,
  output hrm_pkg::hrm_sts_t         sts_o,
  input  logic [31:0]               now_us_i,
  input  logic [7:0]                hb_type_i,
  input  logic [7:0]                hb_autopilot_i,
  input  logic [7:0]                hb_base_mode_i,
  input  logic [31:0]               hb_custom_mode_i,
  input  logic [7:0]                hb_system_status_i,
  input  logic [31:0]               low_limit_i,
  input  logic [31:0]               high_limit_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [1:0]                status_code_o,
  output logic [31:0]               window_events_o,
  output logic [31:0]               total_events_o,
  output logic [31:0]               window_us_o,
  output logic [31:0]               rate_q16_o,
  output logic [7:0]                last_type_o,
  output logic [7:0]                last_autopilot_o,
  output logic [7:0]                last_base_mode_o,
  output logic [31:0]               last_custom_mode_o,
  output logic [7:0]                last_system_status_o
);
  import hrm_pkg::*;

  localparam int unsigned IdxW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic [DataW-1:0] event_count_q;
  logic [7:0]       held_type_q;
  logic [7:0]       held_autopilot_q;
  logic [7:0]       held_base_mode_q;
  logic [31:0]      held_custom_mode_q;
  logic [7:0]       held_system_status_q;

  logic [DataW-1:0] time_mem [WINDOW_DEPTH];
  logic [DataW-1:0] count_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] slot_valid_q;
  logic [IdxW-1:0]  ring_idx_q;

  logic [DataW-1:0] now_q;
  logic [DataW-1:0] rd_time_q;
  logic [DataW-1:0] rd_count_q;
  logic             rd_valid_q;
  logic [DataW-1:0] events_q;
  logic [DataW-1:0] span_q;
  logic [ProdW-1:0] prod_q;

  logic             div_done;
  logic [DataW-1:0] div_quot;
  logic [DataW-1:0] rate;
  status_e          code;

  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [DataW-1:0] win_events_q;
  logic [DataW-1:0] total_q;
  logic [DataW-1:0] win_us_q;
  logic [DataW-1:0] rate_q;
  logic [7:0]       last_type_q;
  logic [7:0]       last_autopilot_q;
  logic [7:0]       last_base_mode_q;
  logic [31:0]      last_custom_mode_q;
  logic [7:0]       last_system_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_count_q        <= '0;
      held_type_q          <= '0;
      held_autopilot_q     <= '0;
      held_base_mode_q     <= '0;
      held_custom_mode_q   <= '0;
      held_system_status_q <= '0;
    end else if (cmd_i.ev_take) begin
      event_count_q        <= event_count_q + 1'b1;
      held_type_q          <= hb_type_i;
      held_autopilot_q     <= hb_autopilot_i;
      held_base_mode_q     <= hb_base_mode_i;
      held_custom_mode_q   <= hb_custom_mode_i;
      held_system_status_q <= hb_system_status_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      ring_idx_q   <= '0;
    end else if (cmd_i.chk_update) begin
      slot_valid_q[ring_idx_q] <= 1'b1;
      if (ring_idx_q == IdxW'(WINDOW_DEPTH - 1)) begin
        ring_idx_q <= '0;
      end else begin
        ring_idx_q <= ring_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.chk_update) begin
      time_mem[ring_idx_q]  <= now_q;
      count_mem[ring_idx_q] <= event_count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.chk_read) begin
      now_q      <= now_us_i;
      rd_time_q  <= time_mem[ring_idx_q];
      rd_count_q <= count_mem[ring_idx_q];
      rd_valid_q <= slot_valid_q[ring_idx_q];
    end
    if (cmd_i.chk_update) begin
      events_q <= event_count_q - (rd_valid_q ? rd_count_q : '0);
      span_q   <= now_q - (rd_valid_q ? rd_time_q : '0);
    end
    if (cmd_i.mult) begin
      prod_q <= events_q * UsPerSec;
    end
  end

  hrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({prod_q, {FracW{1'b0}}}),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    rate = (span_q == '0) ? '1 : div_quot;
    if (events_q == '0) begin
      code = StNoEvents;
    end else if (rate < low_limit_i) begin
      code = StTooLow;
    end else if (rate > high_limit_i) begin
      code = StTooHigh;
    end else begin
      code = StNormal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q             <= code;
      win_events_q         <= events_q;
      total_q              <= event_count_q;
      win_us_q             <= span_q;
      rate_q               <= rate;
      last_type_q          <= held_type_q;
      last_autopilot_q     <= held_autopilot_q;
      last_base_mode_q     <= held_base_mode_q;
      last_custom_mode_q   <= held_custom_mode_q;
      last_system_status_q <= held_system_status_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = ~out_valid_q | ~out_stall_i;

  assign out_valid_o          = out_valid_q;
  assign status_code_o        = status_q;
  assign window_events_o      = win_events_q;
  assign total_events_o       = total_q;
  assign window_us_o          = win_us_q;
  assign rate_q16_o           = rate_q;
  assign last_type_o          = last_type_q;
  assign last_autopilot_o     = last_autopilot_q;
  assign last_base_mode_o     = last_base_mode_q;
  assign last_custom_mode_o   = last_custom_mode_q;
  assign last_system_status_o = last_system_status_q;

endmodule

FILE: rtl/heartbeat_rate_monitor.sv
// Top level of the heartbeat rate monitor: register port and assembly.
// Depends on hrm_pkg, hrm_ctrl and hrm_datapath.
//
// A heartbeat event item gives no result and leaves the block idle. A check
// item occupies the block from its transfer until its result is in the output
// register, mostly in the bit-serial divider that resolves one of the 68
// dividend bits per cycle; the next item is taken once that result is loaded,
// even if it has not yet been taken downstream. The sample ring needs no
// clearing pass: each slot has a valid bit that reset clears, and an unwritten
// slot reads as zero time and zero count. The rate is events times 10^6 times
// 2^16 over the window in microseconds, truncated and saturated to all ones.
// Limits are written over the register port at byte offsets 0 (low) and 4
// (high); the user must write them only while the block is idle, as the block itself does not enforce it.
module heartbeat_rate_monitor #(
  parameter int unsigned WINDOW_DEPTH = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] now_us_i,
  input  logic [7:0]  hb_type_i,
  input  logic [7:0]  hb_autopilot_i,
  input  logic [7:0]  hb_base_mode_i,
  input  logic [31:0] hb_custom_mode_i,
  input  logic [7:0]  hb_system_status_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_code_o,
  output logic [31:0] window_events_o,
  output logic [31:0] total_events_o,
  output logic [31:0] window_us_o,
  output logic [31:0] rate_q16_o,
  output logic [7:0]  last_type_o,
  output logic [7:0]  last_autopilot_o,
  output logic [7:0]  last_base_mode_o,
  output logic [31:0] last_custom_mode_o,
  output logic [7:0]  last_system_status_o
);
  import hrm_pkg::*;

  logic [DataW-1:0] low_limit_q;
  logic [DataW-1:0] high_limit_q;
  logic             reg_wr;
  reg_e             reg_sel;
  hrm_cmd_t         cmd;
  hrm_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= LowLimitRst;
      high_limit_q <= HighLimitRst;
    end else if (reg_wr) begin
      case (reg_sel)
        RegLowLimit:  low_limit_q  <= pwdata;
        RegHighLimit: high_limit_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  assign prdata = (reg_sel == RegHighLimit) ? high_limit_q : low_limit_q;

  hrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hrm_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .now_us_i             (now_us_i),
    .hb_type_i            (hb_type_i),
    .hb_autopilot_i       (hb_autopilot_i),
    .hb_base_mode_i       (hb_base_mode_i),
    .hb_custom_mode_i     (hb_custom_mode_i),
    .hb_system_status_i   (hb_system_status_i),
    .low_limit_i          (low_limit_q),
    .high_limit_i         (high_limit_q),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .status_code_o        (status_code_o),
    .window_events_o      (window_events_o),
    .total_events_o       (total_events_o),
    .window_us_o          (window_us_o),
    .rate_q16_o           (rate_q16_o),
    .last_type_o          (last_type_o),
    .last_autopilot_o     (last_autopilot_o),
    .last_base_mode_o     (last_base_mode_o),
    .last_custom_mode_o   (last_custom_mode_o),
    .last_system_status_o (last_system_status_o)
  );

  a_check_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OpCheck)) |=> in_stall_o)
    else $error("input taken while a check transfer is in progress");

  a_no_events_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_code_o == StNoEvents) == (window_events_o == '0)))
    else $error("no-events code disagrees with the window event count");

  a_zero_window_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (window_us_o == '0)) |-> (rate_q16_o == '1))
    else $error("zero window did not give a saturated rate");

endmodule
